FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion wrappers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/fctu_pkg.sv
// ----------------------------------------------------------------------------
// fctu_pkg
// shared widths, codes, beat types and the fixed mac roman table
// ----------------------------------------------------------------------------
package fctu_pkg;

   localparam int BYTE_W      = 8;
   localparam int CP_W        = 21;
   localparam int WORD_W      = 16;
   localparam int TABLE_DEPTH = 256;
   localparam int REQ_DATA_W  = 40;
   localparam int CSR_IDX_W   = 1;

   typedef enum logic {
      CMD_DECODE = 1'b0,
      CMD_LOAD   = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IDENTITY_TWO_BYTE = 1'b0,
      CSR_MAC_ROMAN         = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      SRC_PAIR,
      SRC_MAC,
      SRC_TABLE,
      SRC_BYTE
   } src_type;

   typedef struct packed {
      logic              vld;
      src_type           src;
      logic [WORD_W-1:0] word;
      logic [CP_W-1:0]   tbl_cp;
   } front_beat_type;

   localparam logic [WORD_W-1:0] MAC_HIGH [0:127] = '{
      16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
      16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
      16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
      16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
      16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
      16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
      16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
      16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
      16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
      16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
      16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
      16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
      16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
      16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
      16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
      16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
   };

endpackage

FILE: sv/fctu_front.sv
// ----------------------------------------------------------------------------
// fctu_front
// input register, pending high byte, code-point table and source selection
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fctu_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // code_byte[7:0], entry_index[15:8], entry_code_point[36:16], entry_valid[37]
   input  logic [fctu_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic                            req_tuser,
   // end_of_string
   input  logic                            req_tlast,
   input  logic                            identity_two_byte,
   input  logic                            mac_roman,
   output fctu_pkg::front_beat_type        beat,
   input  logic                            take
);
   import fctu_pkg::*;

   logic                  accept;
   logic                  is_load;
   logic                  is_decode;
   logic [BYTE_W-1:0]     code_byte;
   logic [BYTE_W-1:0]     entry_index;
   logic [CP_W-1:0]       entry_cp;
   logic                  entry_valid;
   logic                  emit;

   logic [CP_W-1:0]       tbl_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] tbl_vld_ff;
   logic [CP_W-1:0]       rd_ff;

   logic                  pend_vld_ff, pend_vld_in;
   logic [BYTE_W-1:0]     pend_high_ff, pend_high_in;
   logic                  s1_vld_ff, s1_vld_in;
   src_type               src_ff, src_in;
   logic [WORD_W-1:0]     word_ff, word_in;

   assign code_byte   = req_tdata[7:0];
   assign entry_index = req_tdata[15:8];
   assign entry_cp    = req_tdata[36:16];
   assign entry_valid = req_tdata[37];

   assign req_tready = !s1_vld_ff || take;
   assign accept     = req_tvalid && req_tready;
   assign is_load    = cmd_type'(req_tuser) == CMD_LOAD;
   assign is_decode  = cmd_type'(req_tuser) == CMD_DECODE;
   assign emit       = accept && is_decode && (!identity_two_byte || pend_vld_ff);

   always_comb begin
      pend_vld_in  = pend_vld_ff;
      pend_high_in = pend_high_ff;
      if (accept && is_decode) begin
         if (identity_two_byte && !pend_vld_ff) begin
            pend_vld_in  = !req_tlast;
            pend_high_in = req_tlast ? '0 : code_byte;
         end else begin
            pend_vld_in  = 1'b0;
            pend_high_in = '0;
         end
      end
   end

   always_comb begin
      word_in = {{(WORD_W-BYTE_W){1'b0}}, code_byte};
      if (identity_two_byte) begin
         src_in  = SRC_PAIR;
         word_in = {pend_high_ff, code_byte};
      end else if (mac_roman && code_byte[BYTE_W-1]) begin
         src_in = SRC_MAC;
      end else if (tbl_vld_ff[code_byte]) begin
         src_in = SRC_TABLE;
      end else begin
         src_in = SRC_BYTE;
      end
   end

   always_comb begin
      s1_vld_in = s1_vld_ff && !take;
      if (accept) begin
         s1_vld_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_load) begin
         tbl_mem[entry_index] <= entry_cp;
      end
      if (accept) begin
         rd_ff   <= tbl_mem[code_byte];
         src_ff  <= src_in;
         word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_vld_ff   <= '0;
         pend_vld_ff  <= 1'b0;
         pend_high_ff <= '0;
         s1_vld_ff    <= 1'b0;
      end else begin
         if (accept && is_load) begin
            tbl_vld_ff[entry_index] <= entry_valid;
         end
         pend_vld_ff  <= pend_vld_in;
         pend_high_ff <= pend_high_in;
         s1_vld_ff    <= s1_vld_in;
      end
   end

   assign beat.vld    = s1_vld_ff;
   assign beat.src    = src_ff;
   assign beat.word   = word_ff;
   assign beat.tbl_cp = rd_ff;

   `ASSERT_NEXT(a_load_no_beat, clock, reset, accept && is_load, !s1_vld_ff,
      "table load produced a character beat")
   `ASSERT_NEXT(a_single_byte_beat, clock, reset, accept && is_decode && !identity_two_byte,
      s1_vld_ff && !pend_vld_ff, "single-byte decode did not produce a beat")

endmodule

FILE: sv/fctu_serializer.sv
// ----------------------------------------------------------------------------
// fctu_serializer
// code-point selection, utf-8 encoding and byte-wide output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fctu_serializer (
   input  logic                        clock,
   input  logic                        reset,
   input  fctu_pkg::front_beat_type    beat,
   output logic                        take,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // utf8_byte
   output logic [fctu_pkg::BYTE_W-1:0] rsp_tdata,
   // last
   output logic                        rsp_tlast
);
   import fctu_pkg::*;

   logic [CP_W-1:0]   cp;
   logic [BYTE_W-1:0] enc [4];
   logic [1:0]        enc_last;

   logic              busy_ff, busy_in;
   logic [1:0]        idx_ff, idx_in;
   logic [1:0]        last_idx_ff;
   logic [BYTE_W-1:0] byte_ff [4];
   logic              done;

   always_comb begin
      case (beat.src)
         SRC_PAIR:  cp = {{(CP_W-WORD_W){1'b0}}, beat.word};
         SRC_MAC:   cp = {{(CP_W-WORD_W){1'b0}}, MAC_HIGH[beat.word[6:0]]};
         SRC_TABLE: cp = beat.tbl_cp;
         SRC_BYTE:  cp = {{(CP_W-BYTE_W){1'b0}}, beat.word[BYTE_W-1:0]};
         default:   cp = '0;
      endcase
   end

   always_comb begin
      enc[0] = '0;
      enc[1] = '0;
      enc[2] = '0;
      enc[3] = '0;
      if (cp <= CP_W'(32'h7F)) begin
         enc[0]   = cp[7:0];
         enc_last = 2'd0;
      end else if (cp <= CP_W'(32'h7FF)) begin
         enc[0]   = 8'hC0 | {3'b000, cp[10:6]};
         enc[1]   = 8'h80 | {2'b00, cp[5:0]};
         enc_last = 2'd1;
      end else if (cp <= CP_W'(32'hFFFF)) begin
         enc[0]   = 8'hE0 | {4'b0000, cp[15:12]};
         enc[1]   = 8'h80 | {2'b00, cp[11:6]};
         enc[2]   = 8'h80 | {2'b00, cp[5:0]};
         enc_last = 2'd2;
      end else begin
         enc[0]   = 8'hF0 | {5'b00000, cp[20:18]};
         enc[1]   = 8'h80 | {2'b00, cp[17:12]};
         enc[2]   = 8'h80 | {2'b00, cp[11:6]};
         enc[3]   = 8'h80 | {2'b00, cp[5:0]};
         enc_last = 2'd3;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = byte_ff[idx_ff];
   assign rsp_tlast  = idx_ff == last_idx_ff;
   assign done       = busy_ff && rsp_tready && rsp_tlast;
   assign take       = beat.vld && (!busy_ff || done);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (take) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_tready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff     <= enc;
         last_idx_ff <= enc_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   `ASSERT_IMPLIES(a_idx_range, clock, reset, busy_ff, idx_ff <= last_idx_ff,
      "byte index past end of character")
   `ASSERT_IMPLIES(a_cont_byte, clock, reset, busy_ff && idx_ff != 2'd0,
      rsp_tdata[7:6] == 2'b10, "continuation byte lacks 10 prefix")
   `ASSERT_IMPLIES(a_lead_byte, clock, reset, busy_ff && idx_ff == 2'd0 && !rsp_tlast,
      rsp_tdata[7:6] == 2'b11, "multi-byte lead byte lacks 11 prefix")

endmodule

FILE: sv/font_code_to_utf8_decoder.sv
// path: a beat is registered in the front stage, then its utf-8 bytes in the
// serializer; one input beat per cycle while the serializer takes each beat; each
// character is 1 to 4 bytes on the byte-wide result port, one per cycle with rsp_tready
// reset: synchronous, active high; clears both csr bits, the pending high byte and
// all 256 table valid bits at once, so the block is ready in the cycle after reset
// ----------------------------------------------------------------------------
// font_code_to_utf8_decoder
// text byte to utf-8 converter with two-byte identity, mac roman and load table
// ----------------------------------------------------------------------------
module font_code_to_utf8_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // code_byte[7:0], entry_index[15:8], entry_code_point[36:16], entry_valid[37]
   input  logic [fctu_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command
   input  logic                               req_tuser,
   // end_of_string
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // utf8_byte
   output logic [fctu_pkg::BYTE_W-1:0]        rsp_tdata,
   // last
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [fctu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic                               csr_wdata
);
   import fctu_pkg::*;

   logic           two_byte_ff;
   logic           mac_ff;
   front_beat_type beat;
   logic           take;

   always_ff @(posedge clock) begin
      if (reset) begin
         two_byte_ff <= 1'b0;
         mac_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_IDENTITY_TWO_BYTE: two_byte_ff <= csr_wdata;
            CSR_MAC_ROMAN:         mac_ff      <= csr_wdata;
            default:               ;
         endcase
      end
   end

   fctu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .req_tlast         (req_tlast),
      .identity_two_byte (two_byte_ff),
      .mac_roman         (mac_ff),
      .beat              (beat),
      .take              (take)
   );

   fctu_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
